@@ rtl/rtll_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// rtll_pkg
// Shared types and constants for the range table lerp lookup block.
// ---------------------------------------------------------------------------
package rtll_pkg;

    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_VALUE_WIDTH = 32;

    // fixed field widths
    localparam int FIELD_W     = 32;
    localparam int INDEX_W     = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_LEN_W   = 11;
    localparam int FRAC_W      = 16;
    localparam int POS_W       = 48;

    // register reset values
    localparam logic [FIELD_W-1:0]   RST_TABLE_MIN = 32'h0000_0000;
    localparam logic [FIELD_W-1:0]   RST_INV_STEP  = 32'h0001_0000;
    localparam logic [CFG_LEN_W-1:0] RST_TABLE_LEN = 11'd1024;

    // 1.0 in Q.16 position units
    localparam logic [POS_W-1:0] ONE_Q16 = 48'h0000_0001_0000;

    // edges from the accepting edge to the edge that takes the result
    localparam int RESULT_LATENCY = 8;

    typedef enum logic {
        KIND_WRITE  = 1'b0,
        KIND_LOOKUP = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_UNUSABLE  = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TABLE_MIN = 2'd0,
        CFG_INV_STEP  = 2'd1,
        CFG_TABLE_LEN = 2'd2
    } t_cfg_idx;

    // control that rides along each pipeline stage
    typedef struct packed {
        logic    valid;
        t_kind   kind;
        t_status status;
    } t_stage_ctl;

endpackage
`default_nettype wire

@@ rtl/range_table_lerp_lookup.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// range_table_lerp_lookup
// Evenly spaced lookup table with linear interpolation between entries.
// ---------------------------------------------------------------------------
// Usage:
//  - Command channel: an item is taken on a rising edge with start high and
//    busy low. kind selects an entry write (entry_index, entry_value) or a
//    lookup (lookup_point). busy is low except through reset.
//  - Config channel: i_cfg_valid/o_cfg_ready beats carry a register index
//    (0 table_min, 1 inv_step, 2 table_len, 3 ignored) and data. Write only
//    while no item is in flight.
//  - Every item gives one result beat: o_strobe high for one cycle with
//    o_result_value and o_status. Writes return 0 with status ok or bad index.
//  - Throughput is one item per cycle, set by the two table copies that
//    give both neighbor entries in the same read.
//  - The receiver has no stall; results are never held.
//  - Reset is synchronous: pipeline emptied, registers to their defaults.
//    The table has no clear; entries hold garbage until written.
//  - Writes and lookups reach the table in the same stage and in order, so
//    a lookup right behind a write sees the new entry with no bypass.
// ---------------------------------------------------------------------------
module range_table_lerp_lookup #(
    parameter int TABLE_DEPTH = rtll_pkg::DEF_TABLE_DEPTH,
    parameter int VALUE_WIDTH = rtll_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // command channel
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic                                 i_kind,
    input  wire logic        [rtll_pkg::INDEX_W-1:0]  i_entry_index,
    input  wire logic signed [rtll_pkg::FIELD_W-1:0]  i_entry_value,
    input  wire logic signed [rtll_pkg::FIELD_W-1:0]  i_lookup_point,
    // result beats
    output logic                                      o_strobe,
    output logic signed      [rtll_pkg::FIELD_W-1:0]  o_result_value,
    output logic             [1:0]                    o_status,
    // config channel
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic        [rtll_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic        [rtll_pkg::FIELD_W-1:0]  i_cfg_data
);

    import rtll_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int EW = (VALUE_WIDTH > FIELD_W) ? FIELD_W : VALUE_WIDTH;
    localparam int PW = EW + 1 + FRAC_W + 1;

    // busy only through reset
    logic r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy        = r_busy;
    assign o_cfg_ready = !r_busy;

    logic w_accept;
    assign w_accept = start && !r_busy;

    // config registers
    logic signed [FIELD_W-1:0] r_table_min;
    logic        [FIELD_W-1:0] r_inv_step;
    logic        [CFG_LEN_W-1:0] r_table_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_min <= RST_TABLE_MIN;
            r_inv_step  <= RST_INV_STEP;
            r_table_len <= RST_TABLE_LEN;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_TABLE_MIN: r_table_min <= i_cfg_data;
                CFG_INV_STEP:  r_inv_step  <= i_cfg_data;
                CFG_TABLE_LEN: r_table_len <= i_cfg_data[CFG_LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // front half: position and addresses
    t_stage_ctl        w_s4_ctl;
    logic              w_wr_en;
    logic [EW-1:0]     w_wr_data;
    logic [AW-1:0]     w_addr0;
    logic [AW-1:0]     w_addr1;
    logic [FRAC_W-1:0] w_s4_frac;

    rtll_posmap #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_posmap (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_kind         (i_kind),
        .i_entry_index  (i_entry_index),
        .i_entry_value  (i_entry_value),
        .i_lookup_point (i_lookup_point),
        .i_table_min    (r_table_min),
        .i_inv_step     (r_inv_step),
        .i_table_len    (r_table_len),
        .o_ctl          (w_s4_ctl),
        .o_wr_en        (w_wr_en),
        .o_wr_data      (w_wr_data),
        .o_addr0        (w_addr0),
        .o_addr1        (w_addr1),
        .o_frac         (w_s4_frac)
    );

    // two copies of the table, written together; copy 0 gives the entry at
    // the integer part, copy 1 the next (wrapped) entry
    logic [EW-1:0] w_e0_raw;
    logic [EW-1:0] w_e1_raw;

    rtll_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_table_lo (
        .i_clk   (i_clk),
        .i_we    (w_wr_en),
        .i_waddr (w_addr0),
        .i_wdata (w_wr_data),
        .i_raddr (w_addr0),
        .o_rdata (w_e0_raw)
    );

    rtll_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_table_hi (
        .i_clk   (i_clk),
        .i_we    (w_wr_en),
        .i_waddr (w_addr0),
        .i_wdata (w_wr_data),
        .i_raddr (w_addr1),
        .o_rdata (w_e1_raw)
    );

    // stage 5: table data arrives
    t_stage_ctl        r_s5_ctl;
    logic [FRAC_W-1:0] r_s5_frac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_ctl <= '0;
        end else begin
            r_s5_ctl <= w_s4_ctl;
        end
        r_s5_frac <= w_s4_frac;
    end

    // stage 6: slope between neighbors
    logic signed [EW-1:0] w_e0;
    logic signed [EW-1:0] w_e1;
    t_stage_ctl           r_s6_ctl;
    logic signed [EW:0]   r_s6_delta, n_s6_delta;
    logic signed [EW-1:0] r_s6_e0;
    logic [FRAC_W-1:0]    r_s6_frac;

    assign w_e0       = w_e0_raw;
    assign w_e1       = w_e1_raw;
    assign n_s6_delta = (EW + 1)'(w_e1) - (EW + 1)'(w_e0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_ctl <= '0;
        end else begin
            r_s6_ctl <= r_s5_ctl;
        end
        r_s6_delta <= n_s6_delta;
        r_s6_e0    <= w_e0;
        r_s6_frac  <= r_s5_frac;
    end

    // stage 7: slope times fraction
    t_stage_ctl           r_s7_ctl;
    logic signed [PW-1:0] r_s7_prod, n_s7_prod;
    logic signed [EW-1:0] r_s7_e0;

    assign n_s7_prod = r_s6_delta * $signed({1'b0, r_s6_frac});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_ctl <= '0;
        end else begin
            r_s7_ctl <= r_s6_ctl;
        end
        r_s7_prod <= n_s7_prod;
        r_s7_e0   <= r_s6_e0;
    end

    // output: floor shift of the product added to the lower entry; the sum
    // stays between the two entries
    logic signed [EW+1:0]      w_sum;
    logic signed [EW-1:0]      w_res;
    logic                      r_strobe;
    logic signed [FIELD_W-1:0] r_result_value, n_result_value;
    logic [1:0]                r_status;

    assign w_sum = (EW + 2)'(r_s7_e0) + $signed(r_s7_prod[PW-1:FRAC_W]);
    assign w_res = w_sum[EW-1:0];
    assign n_result_value = (r_s7_ctl.kind == KIND_LOOKUP && r_s7_ctl.status == ST_OK) ?
                            FIELD_W'(w_res) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_s7_ctl.valid;
        end
        r_result_value <= n_result_value;
        r_status       <= r_s7_ctl.status;
    end

    assign o_strobe       = r_strobe;
    assign o_result_value = r_result_value;
    assign o_status       = r_status;

endmodule
`default_nettype wire

@@ rtl/rtll_ram.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// rtll_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module rtll_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 1024,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ rtl/rtll_posmap.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// rtll_posmap
// Front half of the pipe: point to table position, range folding, and the
// two neighbor addresses. Write beats ride along so they reach the table
// in order with lookups.
// ---------------------------------------------------------------------------
module rtll_posmap #(
    parameter  int TABLE_DEPTH = rtll_pkg::DEF_TABLE_DEPTH,
    parameter  int VALUE_WIDTH = rtll_pkg::DEF_VALUE_WIDTH,
    localparam int AW    = $clog2(TABLE_DEPTH),
    localparam int EW    = (VALUE_WIDTH > rtll_pkg::FIELD_W) ? rtll_pkg::FIELD_W : VALUE_WIDTH,
    localparam int LEN_W = ($clog2(TABLE_DEPTH + 1) > rtll_pkg::CFG_LEN_W) ?
                           $clog2(TABLE_DEPTH + 1) : rtll_pkg::CFG_LEN_W
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_accept,
    input  wire logic                                 i_kind,
    input  wire logic        [rtll_pkg::INDEX_W-1:0]  i_entry_index,
    input  wire logic signed [rtll_pkg::FIELD_W-1:0]  i_entry_value,
    input  wire logic signed [rtll_pkg::FIELD_W-1:0]  i_lookup_point,
    input  wire logic signed [rtll_pkg::FIELD_W-1:0]  i_table_min,
    input  wire logic        [rtll_pkg::FIELD_W-1:0]  i_inv_step,
    input  wire logic        [rtll_pkg::CFG_LEN_W-1:0] i_table_len,
    output rtll_pkg::t_stage_ctl                      o_ctl,
    output logic                                      o_wr_en,
    output logic             [EW-1:0]                 o_wr_data,
    output logic             [AW-1:0]                 o_addr0,
    output logic             [AW-1:0]                 o_addr1,
    output logic             [rtll_pkg::FRAC_W-1:0]   o_frac
);

    import rtll_pkg::*;

    localparam int CMP_W = (LEN_W > INDEX_W) ? LEN_W : INDEX_W;

    // effective length, saturated at the table depth
    logic [LEN_W-1:0] w_len_ext;
    logic [LEN_W-1:0] w_eff_len;
    logic [LEN_W-1:0] w_last;
    logic [POS_W-1:0] w_lim;

    assign w_len_ext = LEN_W'(i_table_len);
    assign w_eff_len = (w_len_ext > LEN_W'(TABLE_DEPTH)) ? LEN_W'(TABLE_DEPTH) : w_len_ext;
    assign w_last    = w_eff_len - LEN_W'(1);
    assign w_lim     = {32'(w_eff_len), 16'h0000};

    // stage 1: offset from table_min, status
    t_stage_ctl              r_s1_ctl, n_s1_ctl;
    logic signed [FIELD_W:0] r_s1_diff, n_s1_diff;
    logic [AW-1:0]           r_s1_idx;
    logic [EW-1:0]           r_s1_wdata;

    always_comb begin
        n_s1_ctl.valid  = i_accept;
        n_s1_ctl.kind   = t_kind'(i_kind);
        n_s1_ctl.status = ST_OK;
        if (t_kind'(i_kind) == KIND_WRITE) begin
            if (CMP_W'(i_entry_index) >= CMP_W'(w_eff_len)) begin
                n_s1_ctl.status = ST_BAD_INDEX;
            end
        end else if (i_inv_step == '0 || w_eff_len == '0) begin
            n_s1_ctl.status = ST_UNUSABLE;
        end
        n_s1_diff = (FIELD_W + 1)'(i_lookup_point) - (FIELD_W + 1)'(i_table_min);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
        end else begin
            r_s1_ctl <= n_s1_ctl;
        end
        r_s1_diff  <= n_s1_diff;
        r_s1_idx   <= i_entry_index[AW-1:0];
        r_s1_wdata <= i_entry_value[EW-1:0];
    end

    // stage 2: scale by the reciprocal step, Q32.32 down to Q.16
    t_stage_ctl         r_s2_ctl;
    logic [POS_W-1:0]   r_s2_pos, n_s2_pos;
    logic [AW-1:0]      r_s2_idx;
    logic [EW-1:0]      r_s2_wdata;
    logic [2*FIELD_W-1:0] w_prod;

    assign w_prod   = r_s1_diff[FIELD_W-1:0] * i_inv_step;
    // non-positive offset pins to entry 0
    assign n_s2_pos = (!r_s1_diff[FIELD_W] && (r_s1_diff[FIELD_W-1:0] != '0)) ?
                      w_prod[2*FIELD_W-1:FRAC_W] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_ctl <= '0;
        end else begin
            r_s2_ctl <= r_s1_ctl;
        end
        r_s2_pos   <= n_s2_pos;
        r_s2_idx   <= r_s1_idx;
        r_s2_wdata <= r_s1_wdata;
    end

    // stage 3: one step back when at or past the end
    t_stage_ctl       r_s3_ctl;
    logic [POS_W-1:0] r_s3_pos, n_s3_pos;
    logic [AW-1:0]    r_s3_idx;
    logic [EW-1:0]    r_s3_wdata;

    assign n_s3_pos = (r_s2_pos >= w_lim) ? (r_s2_pos - ONE_Q16) : r_s2_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_ctl <= '0;
        end else begin
            r_s3_ctl <= r_s2_ctl;
        end
        r_s3_pos   <= n_s3_pos;
        r_s3_idx   <= r_s2_idx;
        r_s3_wdata <= r_s2_wdata;
    end

    // stage 4: still past the end pins to the last entry; neighbor wraps
    t_stage_ctl          r_s4_ctl;
    logic [AW-1:0]       r_s4_addr0, n_s4_addr0;
    logic [AW-1:0]       r_s4_addr1, n_s4_addr1;
    logic [FRAC_W-1:0]   r_s4_frac, n_s4_frac;
    logic [EW-1:0]       r_s4_wdata;
    logic                w_over;
    logic [LEN_W-1:0]    w_int;
    logic [LEN_W-1:0]    w_next;

    assign w_over = (r_s3_pos >= w_lim);
    assign w_int  = r_s3_pos[FRAC_W +: LEN_W];
    assign w_next = w_int + LEN_W'(1);

    always_comb begin
        if (r_s3_ctl.kind == KIND_WRITE) begin
            n_s4_addr0 = r_s3_idx;
        end else if (w_over) begin
            n_s4_addr0 = w_last[AW-1:0];
        end else begin
            n_s4_addr0 = w_int[AW-1:0];
        end
        n_s4_addr1 = (w_over || w_next >= w_eff_len) ? '0 : w_next[AW-1:0];
        n_s4_frac  = w_over ? '0 : r_s3_pos[FRAC_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_ctl <= '0;
        end else begin
            r_s4_ctl <= r_s3_ctl;
        end
        r_s4_addr0 <= n_s4_addr0;
        r_s4_addr1 <= n_s4_addr1;
        r_s4_frac  <= n_s4_frac;
        r_s4_wdata <= r_s3_wdata;
    end

    assign o_ctl     = r_s4_ctl;
    assign o_wr_en   = r_s4_ctl.valid && (r_s4_ctl.kind == KIND_WRITE) &&
                       (r_s4_ctl.status == ST_OK);
    assign o_wr_data = r_s4_wdata;
    assign o_addr0   = r_s4_addr0;
    assign o_addr1   = r_s4_addr1;
    assign o_frac    = r_s4_frac;

endmodule
`default_nettype wire

@@ rtl/rtll_checker.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// rtll_checker
// Port-level checks for the lookup block, bound to the top level.
// ---------------------------------------------------------------------------
module rtll_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                start,
    input wire logic                                busy,
    input wire logic                                i_kind,
    input wire logic                                o_strobe,
    input wire logic signed [rtll_pkg::FIELD_W-1:0] o_result_value,
    input wire logic        [1:0]                   o_status
);

    import rtll_pkg::*;

    logic w_accept;
    assign w_accept = start && !busy;

    // every accepted beat gives its result at the fixed latency
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##RESULT_LATENCY o_strobe)
        else $error("result beat missing after accepted item");

    // error results carry a zero value
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != ST_OK) |-> (o_result_value == '0))
        else $error("error result with nonzero value");

    // writes return zero and never report an unusable table
    a_write_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_kind == KIND_WRITE) |->
            ##RESULT_LATENCY (o_result_value == '0 && o_status != ST_UNUSABLE))
        else $error("bad result for entry write");

    // lookups never report a bad write index
    a_lookup_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_kind == KIND_LOOKUP) |->
            ##RESULT_LATENCY (o_status != ST_BAD_INDEX))
        else $error("lookup reported bad index");

endmodule

bind range_table_lerp_lookup rtll_checker u_rtll_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_kind         (i_kind),
    .o_strobe       (o_strobe),
    .o_result_value (o_result_value),
    .o_status       (o_status)
);
`default_nettype wire
